// File: hdl/sicg_pkg.sv
// Package: shared types, constants and state enum for the strip interval cover block.
package sicg_pkg;

    localparam int MAX_CIRCLES_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int LEN_W   = 20;
    localparam int WID_W   = 10;
    localparam int POS_W   = 20;
    localparam int RAD_W   = 20;
    localparam int CNT_W   = 11;
    localparam int RAD2_W  = 2 * RAD_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_STORE,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_SCAN,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic root_start;
        logic store;
        logic scan_start;
        logic scan_step;
        logic round_end;
        logic cover_init;
        logic clear_set;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic root_done;
        logic scan_last;
        logic covered;
        logic stuck;
    } status_t;

endpackage

// File: hdl/sicg_if.sv
// Interfaces: valid/ready request channels for circles and cover results.
interface sicg_in_if #(parameter int POS_W = 20, parameter int RAD_W = 20);
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] center_pos;
    logic [RAD_W-1:0] radius;
    logic             last_item;
    modport source (output valid, center_pos, radius, last_item, input ready);
    modport sink   (input valid, center_pos, radius, last_item, output ready);
endinterface

interface sicg_out_if #(parameter int CNT_W = 11);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] cover_count;
    logic             impossible;
    modport source (output valid, cover_count, impossible, input ready);
    modport sink   (input valid, cover_count, impossible, output ready);
endinterface

// File: hdl/strip_interval_cover_greedy.sv
// Top level: strip interval cover with greedy minimum count.
//
// Usage. Circles arrive on the input channel as requests carrying center_pos,
// radius and last_item. Each circle that reaches past the strip's half width,
// while the RAMs have room, is turned into an interval [p - h, p + h] in fixed
// point with FRAC_BITS fraction bits and stored in two RAMs; others are dropped.
// A kept circle is loaded, squared, run through the bit-serial square-root
// unit, one root bit per cycle (29 root bits at default sizes), and stored; a
// dropped circle is only loaded and squared. One circle is in work at a time.
// When the circle marked last_item has been handled, the greedy cover runs:
// each round sweeps all stored intervals, one per cycle through the RAM read
// port, and rounds go on until the strip is covered or no progress is made.
// One result request then carries cover_count and impossible. The result is
// held while the receiver stalls; no new circle is taken until it is accepted.
// Reset clears the control state and the stored count; the RAM contents are
// left undefined, since only written entries are read. Configuration writes
// (strip_length at index 0, strip_width at index 1) are taken at any edge
// with cfg_we high but are meant to happen only while the block is idle.
module strip_interval_cover_greedy #(
    parameter int MAX_CIRCLES = sicg_pkg::MAX_CIRCLES_DEF,
    parameter int FRAC_BITS   = sicg_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sicg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sicg_pkg::CFG_DATA_W-1:0]     cfg_data,
    sicg_in_if.sink                             circle,
    sicg_out_if.source                          result
);
    logic [sicg_pkg::LEN_W-1:0] strip_length_reg;
    logic [sicg_pkg::WID_W-1:0] strip_width_reg;
    sicg_pkg::cmd_t    cmd;
    sicg_pkg::status_t status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= sicg_pkg::LEN_W'(1);
            strip_width_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sicg_pkg::REG_STRIP_LENGTH: strip_length_reg <= cfg_data;
                sicg_pkg::REG_STRIP_WIDTH:  strip_width_reg  <= cfg_data[sicg_pkg::WID_W-1:0];
                default: ;
            endcase
        end
    end

    sicg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(circle.valid), .in_last(circle.last_item), .in_ready(circle.ready),
        .out_valid(result.valid), .out_ready(result.ready),
        .status(status), .cmd(cmd)
    );

    sicg_dp #(.MAX_CIRCLES(MAX_CIRCLES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .center_pos(circle.center_pos), .radius(circle.radius),
        .strip_length(strip_length_reg), .strip_width(strip_width_reg),
        .cover_count(result.cover_count), .impossible(result.impossible)
    );
endmodule

// File: hdl/sicg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sicg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/sicg_ctrl.sv
// Controller: state machine sequencing load, square root, store and greedy cover.
module sicg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sicg_pkg::status_t   status,
    output sicg_pkg::cmd_t      cmd
);
    sicg_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sicg_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            sicg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sicg_pkg::ST_SQ;
                    last_next  = in_last;
                end
            end
            sicg_pkg::ST_SQ:
            begin
                if (status.keep)
                    state_next = sicg_pkg::ST_ROOT;
                else if (last_reg)
                    state_next = sicg_pkg::ST_SCAN_START;
                else
                    state_next = sicg_pkg::ST_IDLE;
            end
            sicg_pkg::ST_ROOT:
            begin
                if (status.root_done)
                    state_next = sicg_pkg::ST_STORE;
            end
            sicg_pkg::ST_STORE:
            begin
                state_next = last_reg ? sicg_pkg::ST_SCAN_START : sicg_pkg::ST_IDLE;
            end
            sicg_pkg::ST_SCAN_START:
            begin
                if (status.covered || status.stuck)
                    state_next = sicg_pkg::ST_OUT;
                else
                    state_next = sicg_pkg::ST_SCAN_WAIT;
            end
            sicg_pkg::ST_SCAN_WAIT:
            begin
                state_next = sicg_pkg::ST_SCAN;
            end
            sicg_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = sicg_pkg::ST_ROUND;
            end
            sicg_pkg::ST_ROUND:
            begin
                state_next = sicg_pkg::ST_SCAN_START;
            end
            sicg_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = sicg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sicg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            sicg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sicg_pkg::ST_SQ:
            begin
                cmd.root_start = status.keep;
                cmd.cover_init = !status.keep && last_reg;
            end
            sicg_pkg::ST_STORE:
            begin
                cmd.store      = 1'b1;
                cmd.cover_init = last_reg;
            end
            sicg_pkg::ST_SCAN_START:
            begin
                cmd.scan_start = !(status.covered || status.stuck);
            end
            sicg_pkg::ST_SCAN_WAIT:
            begin
                cmd.scan_step = 1'b0;
            end
            sicg_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            sicg_pkg::ST_ROUND:
            begin
                cmd.round_end = 1'b1;
            end
            sicg_pkg::ST_OUT:
            begin
                out_valid     = 1'b1;
                cmd.clear_set = out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// File: hdl/sicg_dp.sv
// Datapath: radicand, iterative square root, interval store and greedy scan.
module sicg_dp #(
    parameter int MAX_CIRCLES = sicg_pkg::MAX_CIRCLES_DEF,
    parameter int FRAC_BITS   = sicg_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sicg_pkg::cmd_t                  cmd,
    output sicg_pkg::status_t               status,
    input  logic [sicg_pkg::POS_W-1:0]      center_pos,
    input  logic [sicg_pkg::RAD_W-1:0]      radius,
    input  logic [sicg_pkg::LEN_W-1:0]      strip_length,
    input  logic [sicg_pkg::WID_W-1:0]      strip_width,
    output logic [sicg_pkg::CNT_W-1:0]      cover_count,
    output logic                            impossible
);
    localparam int AW     = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int SCW    = $clog2(MAX_CIRCLES + 1);
    localparam int XW     = sicg_pkg::RAD2_W;
    localparam int PAIRS  = (XW + 1) / 2 + FRAC_BITS;
    localparam int RW     = PAIRS + 2;
    localparam int KW     = $clog2(PAIRS + 1);
    // Interval ends: signed, position scaled plus sign and carry.
    localparam int EW     = sicg_pkg::POS_W + FRAC_BITS + 2;

    logic [sicg_pkg::POS_W-1:0] pos_reg;
    logic [sicg_pkg::RAD_W-1:0] rad_reg;
    logic [2*PAIRS-1:0]         xs_reg, xs_next;
    logic [PAIRS-1:0]           root_reg, root_next;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [KW-1:0]              k_reg;
    logic                       run_reg;

    logic [SCW-1:0] stored_reg;
    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  rd_idx;
    logic           scan_v_reg;
    logic signed [EW-1:0] reach_reg, best_reg;
    logic [sicg_pkg::CNT_W-1:0] used_reg;
    logic stuck_reg;

    logic [2*sicg_pkg::RAD_W-1:0] r2;
    logic [2*sicg_pkg::WID_W-1:0] sw2;
    logic [XW-1:0] four_r2, w2;
    logic [RW-1:0] trial, rem_sh;
    logic signed [EW-1:0] c_val, h_val, target, l_rd, r_rd;
    logic [EW-1:0] l_raw, r_raw;

    assign r2      = rad_reg * rad_reg;
    assign four_r2 = {r2, 2'b00};
    assign sw2     = strip_width * strip_width;
    assign w2      = XW'(sw2);

    // Radicand and square-root registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg <= center_pos;
            rad_reg <= radius;
        end
        if (cmd.root_start)
        begin
            xs_reg   <= (2*PAIRS)'(four_r2 - w2) << (2*PAIRS - XW);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            xs_reg   <= xs_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            k_reg   <= '0;
        end
        else if (cmd.root_start)
        begin
            run_reg <= 1'b1;
            k_reg   <= KW'(PAIRS);
        end
        else if (run_reg)
        begin
            k_reg   <= k_reg - 1'b1;
            run_reg <= (k_reg != KW'(1));
        end
    end

    // One result bit per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg[RW-3:0], xs_reg[2*PAIRS-1 -: 2]};
        trial   = {root_reg, 2'b01};
        xs_next = xs_reg << 2;
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[PAIRS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[PAIRS-2:0], 1'b0};
        end
    end

    assign status.keep      = (four_r2 > w2) && (stored_reg < SCW'(MAX_CIRCLES));
    assign status.root_done = !run_reg;

    assign h_val  = EW'(root_reg >> 1);
    assign c_val  = EW'(pos_reg) << FRAC_BITS;
    assign target = EW'(strip_length) << FRAC_BITS;

    // The read address runs one step ahead so the data matches idx_reg in the scan.
    always_comb
    begin
        rd_idx = idx_reg;
        if (cmd.scan_start)
            rd_idx = '0;
        else if (cmd.scan_step && (SCW'(idx_reg) + 1'b1 < stored_reg))
            rd_idx = idx_reg + 1'b1;
    end

    sicg_ram #(.WIDTH(EW), .DEPTH(MAX_CIRCLES)) u_left (
        .clk(clk), .we(cmd.store), .waddr(stored_reg[AW-1:0]),
        .wdata(c_val - h_val), .raddr(rd_idx), .rdata(l_raw)
    );
    sicg_ram #(.WIDTH(EW), .DEPTH(MAX_CIRCLES)) u_right (
        .clk(clk), .we(cmd.store), .waddr(stored_reg[AW-1:0]),
        .wdata(c_val + h_val), .raddr(rd_idx), .rdata(r_raw)
    );
    assign l_rd = signed'(l_raw);
    assign r_rd = signed'(r_raw);

    assign status.scan_last = scan_v_reg && (SCW'(idx_reg) + 1'b1 >= stored_reg);
    assign status.covered   = !(reach_reg < target);
    assign status.stuck     = stuck_reg;

    // Greedy cover: one stored interval examined per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            idx_reg    <= '0;
            scan_v_reg <= 1'b0;
            reach_reg  <= '0;
            best_reg   <= '0;
            used_reg   <= '0;
            stuck_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.store)
                stored_reg <= stored_reg + 1'b1;
            if (cmd.cover_init)
            begin
                reach_reg <= '0;
                used_reg  <= '0;
                stuck_reg <= (stored_reg == '0) && !cmd.store;
            end
            if (cmd.scan_start)
            begin
                idx_reg    <= '0;
                best_reg   <= reach_reg;
                scan_v_reg <= 1'b1;
            end
            if (cmd.scan_step)
            begin
                if (l_rd <= reach_reg && r_rd > best_reg)
                    best_reg <= r_rd;
                if (SCW'(idx_reg) + 1'b1 < stored_reg)
                    idx_reg <= idx_reg + 1'b1;
                else
                    scan_v_reg <= 1'b0;
            end
            if (cmd.round_end)
            begin
                if (best_reg <= reach_reg)
                    stuck_reg <= 1'b1;
                else
                begin
                    reach_reg <= best_reg;
                    used_reg  <= used_reg + 1'b1;
                end
            end
            if (cmd.clear_set)
            begin
                stored_reg <= '0;
                stuck_reg  <= 1'b0;
                reach_reg  <= '0;
                used_reg   <= '0;
            end
        end
    end

    assign impossible  = stuck_reg && !status.covered;
    assign cover_count = impossible ? '0 : used_reg;
endmodule
